// ===== rtl/bsmt_pkg.sv =====
// ----------------------------------------------------------------------------
// bsmt_pkg
// Shared types, codes and defaults for the bounded set membership table.
// ----------------------------------------------------------------------------
package bsmt_pkg;

  localparam int unsigned CAPACITY_DEF   = 32;
  localparam int unsigned ELEM_WIDTH_DEF = 32;

  localparam int unsigned KIND_W   = 2;
  localparam int unsigned ELEM_W   = 32;
  localparam int unsigned COUNT_W  = 6;

  // Request kinds; the fourth code is unused and takes no action
  typedef enum logic [KIND_W-1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_LOOKUP = 2'd2
  } bsmt_kind_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SCAN   = 2'd1,
    ST_DRAIN  = 2'd2,
    ST_COMMIT = 2'd3
  } bsmt_state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;    // latch request, restart scan
    logic read;    // read one entry, advance scan index
    logic commit;  // apply update, register result
  } bsmt_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last_read;  // scan index sits on the last entry
  } bsmt_sts_t;

endpackage

// ===== rtl/bsmt_ctrl.sv =====
// ----------------------------------------------------------------------------
// bsmt_ctrl
// Sequencer for one request: load, scan every entry, drain, commit.
// ----------------------------------------------------------------------------
module bsmt_ctrl
  import bsmt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  bsmt_sts_t sts_i,
  output bsmt_cmd_t cmd_o
);

  bsmt_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b1;
    case (state_q)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.read = 1'b1;
        if (sts_i.last_read) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  a_accept_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && state_q == ST_SCAN))
    else $error("accepted request did not start a scan");

  a_commit_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> !busy)
    else $error("controller not idle after commit");

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.read, cmd_o.commit}))
    else $error("more than one datapath command at once");

endmodule

// ===== rtl/bsmt_dpath.sv =====
// ----------------------------------------------------------------------------
// bsmt_dpath
// Entry memory, valid marks, count, scan compare and result registers.
// ----------------------------------------------------------------------------
module bsmt_dpath
  import bsmt_pkg::*;
#(
  parameter int unsigned CAPACITY   = CAPACITY_DEF,
  parameter int unsigned ELEM_WIDTH = ELEM_WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bsmt_cmd_t          cmd_i,
  output bsmt_sts_t          sts_o,
  input  logic [KIND_W-1:0]  kind_i,
  input  logic [ELEM_W-1:0]  element_i,
  output logic               done_o,
  output logic               ok_o,
  output logic               table_full_o,
  output logic [COUNT_W-1:0] member_count_o,
  output logic               is_empty_o
);

  // Upper element bits past the 32-bit port are always zero, so store no more
  localparam int unsigned StoreW = (ELEM_WIDTH < ELEM_W) ? ELEM_WIDTH : ELEM_W;
  localparam int unsigned IdxW   = $clog2(CAPACITY);
  localparam int unsigned CntW   = $clog2(CAPACITY + 1);

  logic [StoreW-1:0] mem_q [CAPACITY];
  logic [CAPACITY-1:0] valid_q;
  logic [CntW-1:0]     cnt_q;

  logic [KIND_W-1:0] kind_q;
  logic [StoreW-1:0] key_q;
  logic [IdxW-1:0]   rd_idx_q;

  logic [StoreW-1:0] rd_data_q;
  logic              rd_vld_q;
  logic [IdxW-1:0]   cmp_idx_q;
  logic              cmp_en_q;

  logic              hit_q, free_q;
  logic [IdxW-1:0]   hit_idx_q, free_idx_q;

  logic ok_q, full_q, done_q;
  logic do_write;

  assign sts_o.last_read = (rd_idx_q == IdxW'(CAPACITY - 1));
  assign do_write = cmd_i.commit && (kind_q == KIND_ADD) && !hit_q && free_q;

  // Entry storage: one read port for the scan, one write port at commit
  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      rd_data_q <= mem_q[rd_idx_q];
    end
    if (do_write) begin
      mem_q[free_idx_q] <= key_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= kind_i;
      key_q  <= element_i[StoreW-1:0];
    end
    if (cmd_i.read) begin
      rd_vld_q  <= valid_q[rd_idx_q];
      cmp_idx_q <= rd_idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q   <= '0;
      cmp_en_q   <= 1'b0;
      hit_q      <= 1'b0;
      free_q     <= 1'b0;
      hit_idx_q  <= '0;
      free_idx_q <= '0;
      valid_q    <= '0;
      cnt_q      <= '0;
      done_q     <= 1'b0;
      ok_q       <= 1'b0;
      full_q     <= 1'b0;
    end else begin
      cmp_en_q <= cmd_i.read;
      done_q   <= cmd_i.commit;

      if (cmd_i.load) begin
        rd_idx_q <= '0;
        hit_q    <= 1'b0;
        free_q   <= 1'b0;
      end else if (cmd_i.read) begin
        rd_idx_q <= rd_idx_q + IdxW'(1);
      end

      // Keep the first matching entry and the lowest free entry
      if (cmp_en_q) begin
        if (rd_vld_q && (rd_data_q == key_q) && !hit_q) begin
          hit_q     <= 1'b1;
          hit_idx_q <= cmp_idx_q;
        end
        if (!rd_vld_q && !free_q) begin
          free_q     <= 1'b1;
          free_idx_q <= cmp_idx_q;
        end
      end

      if (cmd_i.commit) begin
        ok_q   <= 1'b0;
        full_q <= 1'b0;
        case (kind_q)
          KIND_ADD: begin
            if (!hit_q) begin
              if (free_q) begin
                valid_q[free_idx_q] <= 1'b1;
                cnt_q               <= cnt_q + CntW'(1);
                ok_q                <= 1'b1;
              end else begin
                full_q <= 1'b1;
              end
            end
          end
          KIND_REMOVE: begin
            if (hit_q) begin
              valid_q[hit_idx_q] <= 1'b0;
              if (cnt_q != '0) begin
                cnt_q <= cnt_q - CntW'(1);
              end
              ok_q <= 1'b1;
            end
          end
          KIND_LOOKUP: begin
            ok_q <= hit_q;
          end
          default: begin
            ok_q <= 1'b0;
          end
        endcase
      end
    end
  end

  assign done_o         = done_q;
  assign ok_o           = ok_q;
  assign table_full_o   = full_q;
  assign member_count_o = COUNT_W'(cnt_q);
  assign is_empty_o     = (cnt_q == '0);

  a_count_tracks_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(cnt_q))
    else $error("held count differs from number of valid entries");

  a_ok_excludes_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !(ok_q && full_q))
    else $error("result both successful and full");

  a_full_only_when_all_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && full_q) |-> (valid_q == {CAPACITY{1'b1}}))
    else $error("full reported with a free entry");

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe held for more than one cycle");

endmodule

// ===== rtl/bounded_set_membership_table.sv =====
// ----------------------------------------------------------------------------
// bounded_set_membership_table
// Set of distinct elements in a bounded table with add, remove and lookup.
// After a request is taken, the scan reads one entry per cycle through the
// single memory read port, then passes the drain and commit states; the result
// strobe done_o is registered from the commit. A new request is taken only
// when idle; busy drops as done_o shows.
// The receiver cannot stall: the result strobe done_o is high for one cycle only.
// Reset clears all valid marks and the count at once; no clearing pass.
// ----------------------------------------------------------------------------
module bounded_set_membership_table
  import bsmt_pkg::*;
#(
  parameter int unsigned CAPACITY   = CAPACITY_DEF,
  parameter int unsigned ELEM_WIDTH = ELEM_WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Request side: taken when start is high and busy is low
  input  logic               start,
  output logic               busy,
  input  logic [KIND_W-1:0]  kind_i,
  input  logic [ELEM_W-1:0]  element_i,
  // Result side: valid for exactly one cycle while done_o is high
  output logic               done_o,
  output logic               ok_o,
  output logic               table_full_o,
  output logic [COUNT_W-1:0] member_count_o,
  output logic               is_empty_o
);

  bsmt_cmd_t cmd;
  bsmt_sts_t sts;

  // Sequence each request: load, scan all entries, drain the compare, commit
  bsmt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // Hold entries, valid marks and count; compare one entry per cycle
  bsmt_dpath #(
    .CAPACITY   (CAPACITY),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .kind_i         (kind_i),
    .element_i      (element_i),
    .done_o         (done_o),
    .ok_o           (ok_o),
    .table_full_o   (table_full_o),
    .member_count_o (member_count_o),
    .is_empty_o     (is_empty_o)
  );

endmodule
